// ----- design/tes_pkg.sv -----
// ----------------------------------------------------------------------------
// tes_pkg: shared types and constants
// Widths, register indexes, sequencer states and divider handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package tes_pkg;

  localparam int SAMPLE_BITS  = 32;
  localparam int COUNT_BITS   = 20;
  localparam int FRAC_BITS    = 8;
  localparam int SUM_BITS     = 52;
  localparam int RUN_BITS     = COUNT_BITS + FRAC_BITS;
  localparam int EXCESS_BITS  = 32;
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS);
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNDER_MODE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_NODATA     = 2'd2;

  localparam logic signed [SAMPLE_BITS-1:0] THRESHOLD_RESET = 32'sd0;
  localparam logic signed [SAMPLE_BITS-1:0] NODATA_RESET    = -32'sd25344;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN_GO,
    ST_RUN_WAIT,
    ST_EXC_GO,
    ST_EXC_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [SUM_BITS-1:0]   dividend;
    logic [COUNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SUM_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- design/tes_if.sv -----
// ----------------------------------------------------------------------------
// tes_if: sample and result channels
// Valid/ready channels carrying one sample item and one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tes_smp_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [tes_pkg::SAMPLE_BITS-1:0]    sample;
  logic                                      last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface tes_res_if;
  logic                              valid;
  logic                              ready;
  logic [tes_pkg::COUNT_BITS-1:0]    exceed_count;
  logic [tes_pkg::COUNT_BITS-1:0]    event_count;
  logic [tes_pkg::RUN_BITS-1:0]      mean_run_length;
  logic                              run_length_valid;
  logic [tes_pkg::EXCESS_BITS-1:0]   mean_excess;
  logic                              excess_valid;

  modport source (output valid, exceed_count, event_count, mean_run_length,
                  run_length_valid, mean_excess, excess_valid, input ready);
  modport sink   (input valid, exceed_count, event_count, mean_run_length,
                  run_length_valid, mean_excess, excess_valid, output ready);
endinterface

`default_nettype wire

// ----- design/tes_div.sv -----
// ----------------------------------------------------------------------------
// tes_div: shared restoring divider
// One quotient bit per cycle; a wide dividend over a count-wide divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tes_pkg::div_req_t req,
  output tes_pkg::div_rsp_t      rsp
);

  localparam logic [tes_pkg::DIV_CNT_BITS-1:0] LAST_STEP =
    tes_pkg::DIV_CNT_BITS'(tes_pkg::SUM_BITS - 1);

  logic                                busy;
  logic                                done;
  logic [tes_pkg::DIV_CNT_BITS-1:0]    cnt;
  logic [tes_pkg::SUM_BITS-1:0]        quo;
  logic [tes_pkg::COUNT_BITS-1:0]      rem;
  logic [tes_pkg::COUNT_BITS-1:0]      dsr;

  logic [tes_pkg::COUNT_BITS:0]        trial;
  logic [tes_pkg::COUNT_BITS:0]        diff;
  logic                                q_bit;
  logic [tes_pkg::COUNT_BITS-1:0]      rem_next;

  // shift in the next dividend bit and try to subtract the divisor
  assign trial    = {rem, quo[tes_pkg::SUM_BITS-1]};
  assign diff     = trial - {1'b0, dsr};
  assign q_bit    = trial >= {1'b0, dsr};
  assign rem_next = q_bit ? diff[tes_pkg::COUNT_BITS-1:0] : trial[tes_pkg::COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      quo <= {quo[tes_pkg::SUM_BITS-2:0], q_bit};
      rem <= rem_next;
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

`ifndef SYNTH
  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("divider done without a finished run");

  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(req.start))
    else $error("divider busy without a start");
`endif

endmodule

`default_nettype wire

// ----- design/threshold_exceedance_statistics_unit.sv -----
// ----------------------------------------------------------------------------
// threshold_exceedance_statistics_unit: exceedance run statistics
// Counts samples beyond a threshold, closed runs and excess, then averages.
// ----------------------------------------------------------------------------
// Samples (signed Q24.8) arrive on the smp channel; one is taken every cycle
// while the record is being accumulated. A sample equal to the no-data marker
// is dropped. Others exceed the threshold when strictly above it (under_mode
// 0) or strictly below it (under_mode 1); each exceeding sample bumps the
// saturating exceed tally and adds its distance to a 52-bit saturating sum,
// and a non-exceeding sample that ends a run bumps the closed-run count. The
// item flagged last is accumulated like any other and then triggers the
// result: a single restoring divider, one quotient bit per cycle, first forms
// exceed_count * 2^8 / event_count and then excess_sum / exceed_count. The
// sample channel drops ready after a last item: a start state and a wait
// state over the 52 divider steps for each of the two passes through that
// divider, then an output state that loads the result, plus any wait for
// the result register to drain. The result register parts the two sides,
// so accumulation of the next record runs while a result is pending.
// The mean flags are low when their divisor is zero (the mean then reads 0).
// Configuration registers are written through cfg_we/cfg_idx/cfg_wdata:
// index 0 threshold, 1 under_mode, 2 no-data marker; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_exceedance_statistics_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  tes_smp_if.sink                                   smp,
  tes_res_if.source                                 res,
  input  wire logic                                 cfg_we,
  input  wire logic [tes_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
  input  wire logic [tes_pkg::SAMPLE_BITS-1:0]      cfg_wdata
);

  localparam int PAD_BITS = tes_pkg::SUM_BITS - tes_pkg::RUN_BITS;

  // configuration
  logic signed [tes_pkg::SAMPLE_BITS-1:0] threshold;
  logic                                   under_mode;
  logic signed [tes_pkg::SAMPLE_BITS-1:0] nodata_marker;

  // record accumulators
  logic [tes_pkg::COUNT_BITS-1:0] exceed_tally;
  logic [tes_pkg::COUNT_BITS-1:0] closed_runs;
  logic [tes_pkg::SUM_BITS-1:0]   excess_sum;
  logic                           in_run;

  // sequencer
  tes_pkg::state_t  state;
  tes_pkg::state_t  state_next;
  tes_pkg::div_req_t div_req;
  tes_pkg::div_rsp_t div_rsp;

  // quotients captured from the divider
  logic [tes_pkg::RUN_BITS-1:0]    run_mean;
  logic [tes_pkg::EXCESS_BITS-1:0] exc_mean;

  // sample path
  logic                           smp_take;
  logic                           is_valid;
  logic                           exceeds;
  logic [tes_pkg::SAMPLE_BITS:0]  diff_over;
  logic [tes_pkg::SAMPLE_BITS:0]  diff_under;
  logic [tes_pkg::SAMPLE_BITS-1:0] distance;
  logic [tes_pkg::SUM_BITS:0]     sum_wide;

  // result path
  logic res_load;
  logic acc_clear;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= tes_pkg::THRESHOLD_RESET;
      under_mode    <= 1'b0;
      nodata_marker <= tes_pkg::NODATA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tes_pkg::REG_THRESHOLD:  threshold     <= cfg_wdata;
        tes_pkg::REG_UNDER_MODE: under_mode    <= cfg_wdata[0];
        tes_pkg::REG_NODATA:     nodata_marker <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Per-sample classification and distance beyond the threshold
  // --------------------------------------------------------------------------
  assign smp_take   = smp.valid && smp.ready;
  assign is_valid   = smp.sample != nodata_marker;
  assign exceeds    = under_mode ? (smp.sample < threshold) : (smp.sample > threshold);
  assign diff_over  = {smp.sample[tes_pkg::SAMPLE_BITS-1], smp.sample}
                    - {threshold[tes_pkg::SAMPLE_BITS-1], threshold};
  assign diff_under = {threshold[tes_pkg::SAMPLE_BITS-1], threshold}
                    - {smp.sample[tes_pkg::SAMPLE_BITS-1], smp.sample};
  // the distance is positive whenever the sample exceeds, so it fits unsigned
  assign distance   = under_mode ? diff_under[tes_pkg::SAMPLE_BITS-1:0]
                                 : diff_over[tes_pkg::SAMPLE_BITS-1:0];
  assign sum_wide   = {1'b0, excess_sum}
                    + {{(tes_pkg::SUM_BITS + 1 - tes_pkg::SAMPLE_BITS){1'b0}}, distance};

  // --------------------------------------------------------------------------
  // Accumulators: advance on each valid sample, clear once a result is loaded
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst || acc_clear) begin
      exceed_tally <= '0;
      closed_runs  <= '0;
      excess_sum   <= '0;
      in_run       <= 1'b0;
    end else if (smp_take && is_valid) begin
      if (exceeds) begin
        if (exceed_tally != '1) begin
          exceed_tally <= exceed_tally + 1'b1;
        end
        // carry out of the sum means it has passed the ceiling: hold at all ones
        excess_sum <= sum_wide[tes_pkg::SUM_BITS] ? '1 : sum_wide[tes_pkg::SUM_BITS-1:0];
        in_run     <= 1'b1;
      end else if (in_run) begin
        if (closed_runs != '1) begin
          closed_runs <= closed_runs + 1'b1;
        end
        in_run <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared divider
  // --------------------------------------------------------------------------
  tes_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tes_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tes_pkg::ST_IDLE: begin
        if (smp_take && smp.last) begin
          state_next = tes_pkg::ST_RUN_GO;
        end
      end
      tes_pkg::ST_RUN_GO:   state_next = tes_pkg::ST_RUN_WAIT;
      tes_pkg::ST_RUN_WAIT: begin
        if (div_rsp.done) begin
          state_next = tes_pkg::ST_EXC_GO;
        end
      end
      tes_pkg::ST_EXC_GO:   state_next = tes_pkg::ST_EXC_WAIT;
      tes_pkg::ST_EXC_WAIT: begin
        if (div_rsp.done) begin
          state_next = tes_pkg::ST_OUT;
        end
      end
      tes_pkg::ST_OUT: begin
        if (!res.valid || res.ready) begin
          state_next = tes_pkg::ST_IDLE;
        end
      end
      default: state_next = tes_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    smp.ready        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {excess_sum};
    div_req.divisor  = exceed_tally;
    res_load         = 1'b0;
    acc_clear        = 1'b0;
    unique case (state)
      tes_pkg::ST_IDLE: smp.ready = 1'b1;
      tes_pkg::ST_RUN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {{PAD_BITS{1'b0}}, exceed_tally, {tes_pkg::FRAC_BITS{1'b0}}};
        div_req.divisor  = closed_runs;
      end
      tes_pkg::ST_EXC_GO: div_req.start = 1'b1;
      tes_pkg::ST_OUT: begin
        res_load  = !res.valid || res.ready;
        acc_clear = res_load;
      end
      default: ;
    endcase
  end

  // capture each quotient as its pass finishes
  always_ff @(posedge clk) begin
    if (state == tes_pkg::ST_RUN_WAIT && div_rsp.done) begin
      // at most (2^20-1)*2^8 for a nonzero event count, which fits the run-length field
      run_mean <= div_rsp.quotient[tes_pkg::RUN_BITS-1:0];
    end
    if (state == tes_pkg::ST_EXC_WAIT && div_rsp.done) begin
      exc_mean <= (|div_rsp.quotient[tes_pkg::SUM_BITS-1:tes_pkg::EXCESS_BITS])
                ? '1 : div_rsp.quotient[tes_pkg::EXCESS_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Result register: hold until taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.exceed_count     <= exceed_tally;
      res.event_count      <= closed_runs;
      res.run_length_valid <= closed_runs != '0;
      res.mean_run_length  <= (closed_runs != '0) ? run_mean : '0;
      res.excess_valid     <= exceed_tally != '0;
      res.mean_excess      <= (exceed_tally != '0) ? exc_mean : '0;
    end
  end

`ifndef SYNTH
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (smp.valid && smp.ready && smp.last) |=> !smp.ready)
    else $error("sample taken right after a last item");

  a_runs_within_tally: assert property (@(posedge clk) disable iff (rst)
    closed_runs <= exceed_tally)
    else $error("closed runs exceed the exceed tally");

  a_run_flag: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.run_length_valid == (res.event_count != '0)))
    else $error("run-length flag disagrees with event count");

  a_excess_flag: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.excess_valid == (res.exceed_count != '0)))
    else $error("excess flag disagrees with exceed count");

  a_no_load_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!res.valid || res.ready))
    else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: threshold exceedance statistics regression
// Feeds records of Q24.8 samples through the unit under several threshold,
// mode and no-data settings. Expected per-record statistics are worked out
// as each sample item is taken and compared with every result item.
// ----------------------------------------------------------------------------

module testbench;

  localparam int          HALF_PERIOD = 4;
  localparam int          RESET_CYCLES = 12;
  // Two 52-step divider passes plus margin for the result register to drain.
  localparam int          DRAIN_CYCLES = 200;
  localparam int          CYCLE_LIMIT = 500_000;
  localparam int          BACKLOG_DEPTH = 32;
  localparam int          RANDOM_PHASES = 6;
  localparam int          ITEMS_PER_PHASE = 125;

  localparam logic signed [tes_pkg::SAMPLE_BITS-1:0] S_MIN = 32'h8000_0000;
  localparam logic signed [tes_pkg::SAMPLE_BITS-1:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [63:0] SUM_CAP    = (64'd1 << tes_pkg::SUM_BITS) - 1;
  localparam logic [63:0] RUN_CAP    = (64'd1 << tes_pkg::RUN_BITS) - 1;
  localparam logic [63:0] EXCESS_CAP = (64'd1 << tes_pkg::EXCESS_BITS) - 1;

  typedef struct packed {
    logic signed [tes_pkg::SAMPLE_BITS-1:0] sample;
    logic                                   last;
  } sample_item_t;

  typedef struct {
    logic [tes_pkg::COUNT_BITS-1:0]  exceed_count;
    logic [tes_pkg::COUNT_BITS-1:0]  event_count;
    logic [tes_pkg::RUN_BITS-1:0]    mean_run_length;
    logic                            run_length_valid;
    logic [tes_pkg::EXCESS_BITS-1:0] mean_excess;
    logic                            excess_valid;
  } record_stats_t;

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [tes_pkg::CFG_IDX_BITS-1:0] cfg_idx;
  logic [tes_pkg::SAMPLE_BITS-1:0]  cfg_wdata;

  tes_smp_if smp ();
  tes_res_if res ();

  threshold_exceedance_statistics_unit dut (
    .clk       (clk),
    .rst       (rst),
    .smp       (smp),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Items waiting to be offered, and statistics waiting to come out.
  sample_item_t  sample_backlog[$];
  record_stats_t expected_stats[$];

  // Shadow of the configuration registers.
  logic signed [tes_pkg::SAMPLE_BITS-1:0] thr_copy    = tes_pkg::THRESHOLD_RESET;
  logic                                   under_copy  = 1'b0;
  logic signed [tes_pkg::SAMPLE_BITS-1:0] nodata_copy = tes_pkg::NODATA_RESET;

  // Shadow of the per-record accumulators.
  logic [tes_pkg::COUNT_BITS-1:0] tally;
  logic [tes_pkg::COUNT_BITS-1:0] runs;
  logic [tes_pkg::SUM_BITS-1:0]   excess_acc;
  logic                           open_run;

  int           faults;
  int           cycle_count;
  int           feed_pause;
  int           feed_calm;
  int           drain_pause;
  int           drain_calm;
  sample_item_t next_item;
  record_stats_t want;

  always #HALF_PERIOD clk = ~clk;

  // Mostly back-to-back, often a short pause, now and then a long one.
  function automatic int pick_pause();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    else if (roll < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  // Random level around a centre, clamped to the sample range.
  function automatic logic signed [tes_pkg::SAMPLE_BITS-1:0] near_level(
    input logic signed [tes_pkg::SAMPLE_BITS-1:0] centre, input int spread);
    longint v;
    v = longint'(centre) + longint'($urandom_range(0, 2 * spread)) - spread;
    if (v > longint'(S_MAX))
      v = longint'(S_MAX);
    if (v < longint'(S_MIN))
      v = longint'(S_MIN);
    return v[tes_pkg::SAMPLE_BITS-1:0];
  endfunction

  // Accumulate one taken sample; on the last of a record, queue the
  // statistics it must produce and clear for the next record.
  task automatic account_sample(input logic signed [tes_pkg::SAMPLE_BITS-1:0] s,
                                input logic lst);
    logic [63:0]   gap;
    logic [63:0]   quot;
    record_stats_t r;
    if (s != nodata_copy) begin
      if (under_copy ? (s < thr_copy) : (s > thr_copy)) begin
        gap = under_copy ? longint'(thr_copy) - longint'(s)
                         : longint'(s) - longint'(thr_copy);
        if (tally != '1)
          tally = tally + 1'b1;
        if (64'(excess_acc) + gap > SUM_CAP)
          excess_acc = SUM_CAP[tes_pkg::SUM_BITS-1:0];
        else
          excess_acc = excess_acc + gap[tes_pkg::SUM_BITS-1:0];
        open_run = 1'b1;
      end else if (open_run) begin
        if (runs != '1)
          runs = runs + 1'b1;
        open_run = 1'b0;
      end
    end
    if (lst) begin
      r.exceed_count     = tally;
      r.event_count      = runs;
      r.run_length_valid = (runs != 0);
      r.excess_valid     = (tally != 0);
      r.mean_run_length  = '0;
      r.mean_excess      = '0;
      if (runs != 0) begin
        quot = (64'(tally) << tes_pkg::FRAC_BITS) / 64'(runs);
        r.mean_run_length = (quot > RUN_CAP) ? RUN_CAP[tes_pkg::RUN_BITS-1:0]
                                             : quot[tes_pkg::RUN_BITS-1:0];
      end
      if (tally != 0) begin
        quot = 64'(excess_acc) / 64'(tally);
        r.mean_excess = (quot > EXCESS_CAP) ? EXCESS_CAP[tes_pkg::EXCESS_BITS-1:0]
                                            : quot[tes_pkg::EXCESS_BITS-1:0];
      end
      expected_stats.push_back(r);
      tally      = '0;
      runs       = '0;
      excess_acc = '0;
      open_run   = 1'b0;
    end
  endtask

  // Sample driver: offer backlog items, hold them until taken, and account
  // for each item at the edge that takes it.
  always @(posedge clk) begin
    if (rst) begin
      smp.valid   <= 1'b0;
      smp.sample  <= '0;
      smp.last    <= 1'b0;
      feed_pause  = 0;
      feed_calm   = 0;
      tally       = '0;
      runs        = '0;
      excess_acc  = '0;
      open_run    = 1'b0;
    end else begin
      if (smp.valid && smp.ready)
        account_sample(smp.sample, smp.last);
      if (!smp.valid || smp.ready) begin
        if (feed_pause > 0) begin
          smp.valid <= 1'b0;
          feed_pause--;
        end else if (sample_backlog.size() != 0) begin
          next_item = sample_backlog.pop_front();
          smp.valid  <= 1'b1;
          smp.sample <= next_item.sample;
          smp.last   <= next_item.last;
          // Draw the gap before the following item; calm stretches keep
          // the channel busy for a while.
          if (feed_calm > 0) begin
            feed_calm--;
            feed_pause = 0;
          end else if ($urandom_range(0, 15) == 0) begin
            feed_calm  = $urandom_range(16, 64);
            feed_pause = 0;
          end else begin
            feed_pause = pick_pause();
          end
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: stall at random, compare every taken result item with
  // the oldest outstanding expectation.
  always @(posedge clk) begin
    if (rst) begin
      res.ready   <= 1'b0;
      drain_pause = 0;
      drain_calm  = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_stats.size() == 0) begin
          $error("result item with no record outstanding");
          faults++;
        end else begin
          want = expected_stats.pop_front();
          if (res.exceed_count !== want.exceed_count) begin
            $error("exceed_count: expected %0d, got %0d", want.exceed_count, res.exceed_count);
            faults++;
          end
          if (res.event_count !== want.event_count) begin
            $error("event_count: expected %0d, got %0d", want.event_count, res.event_count);
            faults++;
          end
          if (res.mean_run_length !== want.mean_run_length) begin
            $error("mean_run_length: expected %0d, got %0d",
                   want.mean_run_length, res.mean_run_length);
            faults++;
          end
          if (res.run_length_valid !== want.run_length_valid) begin
            $error("run_length_valid: expected %0d, got %0d",
                   want.run_length_valid, res.run_length_valid);
            faults++;
          end
          if (res.mean_excess !== want.mean_excess) begin
            $error("mean_excess: expected %0d, got %0d", want.mean_excess, res.mean_excess);
            faults++;
          end
          if (res.excess_valid !== want.excess_valid) begin
            $error("excess_valid: expected %0d, got %0d", want.excess_valid, res.excess_valid);
            faults++;
          end
        end
      end
      if (drain_pause > 0) begin
        res.ready <= 1'b0;
        drain_pause--;
      end else begin
        res.ready <= 1'b1;
        if (drain_calm > 0)
          drain_calm--;
        else if ($urandom_range(0, 31) == 0)
          drain_calm = $urandom_range(20, 100);
        else
          drain_pause = pick_pause();
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("threshold_exceedance_statistics_unit regression: fail");
      $finish;
    end
  end

  // Hold while the backlog is full, then append one item.
  task automatic queue_sample(input logic signed [tes_pkg::SAMPLE_BITS-1:0] s,
                              input logic lst);
    sample_item_t item;
    item.sample = s;
    item.last   = lst;
    while (sample_backlog.size() >= BACKLOG_DEPTH)
      @(posedge clk);
    sample_backlog.push_back(item);
  endtask

  // Wait until every item is taken and every result has come out, then let
  // the divider finish whatever it may still be doing.
  task automatic settle();
    while (sample_backlog.size() != 0 || smp.valid || expected_stats.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tes_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [tes_pkg::SAMPLE_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      tes_pkg::REG_THRESHOLD:  thr_copy = data;
      tes_pkg::REG_UNDER_MODE: under_copy = data[0];
      tes_pkg::REG_NODATA:     nodata_copy = data;
      default: ;
    endcase
  endtask

  // Write all three registers on consecutive edges, then drop the enable.
  task automatic configure(input logic signed [tes_pkg::SAMPLE_BITS-1:0] thr,
                           input logic [tes_pkg::SAMPLE_BITS-1:0] under_word,
                           input logic signed [tes_pkg::SAMPLE_BITS-1:0] nodata);
    write_reg(tes_pkg::REG_THRESHOLD, thr);
    write_reg(tes_pkg::REG_UNDER_MODE, under_word);
    write_reg(tes_pkg::REG_NODATA, nodata);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic signed [tes_pkg::SAMPLE_BITS-1:0] thr_pick;
    logic signed [tes_pkg::SAMPLE_BITS-1:0] nodata_pick;
    logic signed [tes_pkg::SAMPLE_BITS-1:0] s;
    logic [tes_pkg::SAMPLE_BITS-1:0]        under_word;
    int                                     phase_items;
    int                                     len;
    int                                     spread;
    int                                     pick;

    clk         = 1'b0;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    smp.valid   = 1'b0;
    smp.sample  = '0;
    smp.last    = 1'b0;
    res.ready   = 1'b0;
    faults      = 0;
    cycle_count = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: threshold 0, count above, reset no-data marker.
    // A lone no-data last sample: nothing counted, both means invalid.
    queue_sample(tes_pkg::NODATA_RESET, 1'b1);
    // Run left open at the end of the record.
    queue_sample(32'sd256, 1'b0);
    queue_sample(S_MAX, 1'b0);
    queue_sample(-32'sd256, 1'b0);
    queue_sample(32'sd100, 1'b1);
    // Nothing exceeds; a sample equal to the threshold does not count.
    queue_sample(S_MIN, 1'b0);
    queue_sample(tes_pkg::NODATA_RESET, 1'b0);
    queue_sample(32'sd0, 1'b1);
    // Run closed by the last sample itself.
    queue_sample(32'sd5, 1'b0);
    queue_sample(32'sd0, 1'b1);
    // Several closed runs, fractional mean run length.
    queue_sample(32'sd1, 1'b0);
    queue_sample(32'sd0, 1'b0);
    queue_sample(32'sd1, 1'b0);
    queue_sample(32'sd0, 1'b0);
    queue_sample(32'sd1, 1'b0);
    queue_sample(-32'sd1, 1'b0);
    queue_sample(32'sd2, 1'b1);
    settle();

    // Count below the top threshold; the lowest value marks missing data.
    configure(S_MAX, 32'd1, S_MIN);
    queue_sample(S_MIN, 1'b0);
    queue_sample(S_MIN + 32'sd1, 1'b0);
    queue_sample(S_MAX, 1'b0);
    queue_sample(S_MAX - 32'sd1, 1'b0);
    queue_sample(-32'sd1, 1'b1);
    queue_sample(S_MAX, 1'b1);
    settle();

    // Count above the bottom threshold; no-data gaps do not break a run,
    // and the record ends on a no-data sample.
    configure(S_MIN, 32'd0, S_MAX);
    queue_sample(S_MAX, 1'b0);
    queue_sample(S_MIN, 1'b0);
    queue_sample(S_MIN + 32'sd1, 1'b0);
    queue_sample(S_MAX, 1'b0);
    queue_sample(S_MIN, 1'b0);
    queue_sample(S_MAX, 1'b1);
    queue_sample(32'sd0, 1'b1);

    // Random records under random settings; most samples sit near the
    // threshold so that runs open and close often.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case ($urandom_range(0, 3))
        0:       thr_pick = $urandom;
        1:       thr_pick = $signed($urandom_range(0, 2048)) - 32'sd1024;
        2:       thr_pick = S_MIN;
        default: thr_pick = S_MAX;
      endcase
      pick = $urandom_range(0, 3);
      if (pick < 2)
        nodata_pick = tes_pkg::NODATA_RESET;
      else if (pick == 2)
        nodata_pick = $urandom;
      else
        nodata_pick = near_level(thr_pick, 2);
      // Only bit 0 of the mode word matters; scatter the rest.
      under_word = {$urandom_range(0, 1) ? 31'($urandom) : 31'd0, 1'($urandom_range(0, 1))};
      configure(thr_pick, under_word, nodata_pick);
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        len    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        spread = $urandom_range(0, 1) ? 3 : 2000;
        for (int k = 1; k <= len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 8)
            s = nodata_pick;
          else if (pick < 22)
            s = $urandom;
          else
            s = near_level(thr_pick, spread);
          queue_sample(s, k == len);
        end
        phase_items += len;
      end
    end
    settle();

    if (faults == 0)
      $display("threshold_exceedance_statistics_unit regression: pass");
    else
      $display("threshold_exceedance_statistics_unit regression: fail");
    $finish;
  end

endmodule

// ----- threshold_exceedance_statistics_unit.f -----
design/tes_pkg.sv
design/tes_if.sv
design/tes_div.sv
design/threshold_exceedance_statistics_unit.sv
tb/sv/testbench.sv
